@@ hdl/bhcd_pkg.sv @@
package bhcd_pkg;

  // pwm counter top, duty is scaled to this
  localparam int unsigned PWM_TOP   = 800;
  localparam int unsigned TOP_W     = $clog2(PWM_TOP + 1);

  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned HALL_W    = 3;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned STAGE_W   = 3;
  localparam int unsigned CMP_W     = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 10;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_POINT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN       = 2'd2;

  localparam logic CMD_THROTTLE = 1'b0;
  localparam logic CMD_HALL     = 1'b1;

  localparam logic [PHASE_W-1:0] PH_NONE = 3'b000;
  localparam logic [PHASE_W-1:0] PH_U    = 3'b001;
  localparam logic [PHASE_W-1:0] PH_V    = 3'b010;
  localparam logic [PHASE_W-1:0] PH_W    = 3'b100;

  localparam logic [STAGE_W-1:0] STAGE_OFF = 3'd6;

  localparam logic [SAMPLE_W-1:0] RST_ZERO_POINT = 10'd100;
  localparam logic [SAMPLE_W-1:0] RST_FULL_POINT = 10'd900;
  localparam logic [SAMPLE_W-1:0] RST_SPAN       = 10'd800;

  typedef struct packed {
    logic             done;
    logic [TOP_W-1:0] duty;
  } duty_res_t;

  typedef struct packed {
    logic               valid;
    logic [STAGE_W-1:0] stage;
  } hall_dec_t;

  function automatic hall_dec_t hall_to_stage(input logic [HALL_W-1:0] hall);
    hall_dec_t d;
    d.valid = 1'b1;
    case (hall)
      3'd1:    d.stage = 3'd1;
      3'd2:    d.stage = 3'd3;
      3'd3:    d.stage = 3'd2;
      3'd4:    d.stage = 3'd5;
      3'd5:    d.stage = 3'd0;
      3'd6:    d.stage = 3'd4;
      default: begin
        d.valid = 1'b0;
        d.stage = STAGE_OFF;
      end
    endcase
    return d;
  endfunction

  function automatic logic [PHASE_W-1:0] stage_high(input logic [STAGE_W-1:0] st);
    logic [PHASE_W-1:0] p;
    case (st)
      3'd0, 3'd1: p = PH_U;
      3'd2, 3'd3: p = PH_V;
      3'd4, 3'd5: p = PH_W;
      default:    p = PH_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [PHASE_W-1:0] stage_low(input logic [STAGE_W-1:0] st);
    logic [PHASE_W-1:0] p;
    case (st)
      3'd0, 3'd5: p = PH_V;
      3'd1, 3'd2: p = PH_W;
      3'd3, 3'd4: p = PH_U;
      default:    p = PH_NONE;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/bhcd_duty.sv @@
module bhcd_duty (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bhcd_pkg::SAMPLE_W-1:0] excess,
  input  logic [bhcd_pkg::SAMPLE_W-1:0] span,
  output bhcd_pkg::duty_res_t           res
);
  import bhcd_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + TOP_W;
  localparam int unsigned CNT_W  = $clog2(TOP_W + 1);

  typedef enum logic [2:0] {
    D_IDLE,
    D_MUL,
    D_CHK,
    D_STEP,
    D_DONE
  } dstate_t;

  dstate_t             state_r, state_nxt;
  logic [SAMPLE_W-1:0] excess_r, excess_nxt;
  logic [SAMPLE_W-1:0] span_r, span_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SAMPLE_W-1:0] rem_r, rem_nxt;
  logic [TOP_W-1:0]    lo_r, lo_nxt;
  logic [TOP_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SAMPLE_W:0]   trial;
  logic                qbit;

  // one quotient bit a cycle, remainder stays below span
  assign trial = {rem_r, lo_r[TOP_W-1]};
  assign qbit  = (trial >= {1'b0, span_r});

  always_comb begin
    state_nxt  = state_r;
    excess_nxt = excess_r;
    span_nxt   = span_r;
    prod_nxt   = prod_r;
    rem_nxt    = rem_r;
    lo_nxt     = lo_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          excess_nxt = excess;
          span_nxt   = span;
          ovf_nxt    = 1'b0;
          state_nxt  = D_MUL;
        end
      end
      D_MUL: begin
        prod_nxt  = PROD_W'(excess_r) * PROD_W'(PWM_TOP);
        state_nxt = D_CHK;
      end
      D_CHK: begin
        // top part not below span means the quotient overflows the top anyway
        if (prod_r[PROD_W-1 -: SAMPLE_W] >= span_r) begin
          ovf_nxt   = 1'b1;
          state_nxt = D_DONE;
        end else begin
          rem_nxt   = prod_r[PROD_W-1 -: SAMPLE_W];
          lo_nxt    = prod_r[TOP_W-1:0];
          quo_nxt   = '0;
          cnt_nxt   = CNT_W'(TOP_W);
          state_nxt = D_STEP;
        end
      end
      D_STEP: begin
        rem_nxt = qbit ? SAMPLE_W'(trial - {1'b0, span_r}) : trial[SAMPLE_W-1:0];
        quo_nxt = {quo_r[TOP_W-2:0], qbit};
        lo_nxt  = {lo_r[TOP_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: begin
        state_nxt = D_IDLE;
      end
      default: begin
        state_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
    end
    excess_r <= excess_nxt;
    span_r   <= span_nxt;
    prod_r   <= prod_nxt;
    rem_r    <= rem_nxt;
    lo_r     <= lo_nxt;
    quo_r    <= quo_nxt;
  end

  assign res.done = (state_r == D_DONE);
  assign res.duty = (ovf_r || (quo_r >= TOP_W'(PWM_TOP))) ? TOP_W'(PWM_TOP) : quo_r;

endmodule

@@ hdl/bldc_hall_commutation_duty_unit.sv @@
// hall items and throttle items at or below the zero point, at or above the
// full point or with zero span: result passes the emit state to the output
// register; other throttle items first go through the multiply step and the
// bit-serial divider (one quotient bit per cycle over the compare width)
// one item at a time; the next input is taken as soon as the result is registered
// reset (synchronous, rst_n low): drive off, switches off, compare at top, registers to defaults
module bldc_hall_commutation_duty_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] throttle_sample, [12:10] hall_bits, [15:13] zero
  input  logic [bhcd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] cmd
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] high_phase, [5:3] low_phase, [15:6] compare_value,
  // [18:16] commutation_stage, [19] drive_on, [23:20] zero
  output logic [bhcd_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bhcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bhcd_pkg::CFG_W-1:0]        cfg_data
);
  import bhcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic [SAMPLE_W-1:0]  zero_r, zero_nxt;
  logic [SAMPLE_W-1:0]  full_r, full_nxt;
  logic [SAMPLE_W-1:0]  span_r, span_nxt;
  logic                 drive_r, drive_nxt;
  logic [CMP_W-1:0]     cmp_r, cmp_nxt;
  logic [PHASE_W-1:0]   high_r, high_nxt;
  logic [PHASE_W-1:0]   low_r, low_nxt;
  logic [STAGE_W-1:0]   stage_r, stage_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 in_xfer;
  logic                 cmd;
  logic [SAMPLE_W-1:0]  sample;
  logic [HALL_W-1:0]    hall;
  hall_dec_t            hdec;
  logic                 div_start;
  logic [SAMPLE_W-1:0]  excess;
  duty_res_t            dres;

  assign sample    = in_tdata[SAMPLE_W-1:0];
  assign hall      = in_tdata[SAMPLE_W +: HALL_W];
  assign cmd       = in_tuser;
  assign hdec      = hall_to_stage(hall);
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign excess    = sample - zero_r;

  assign div_start = in_xfer && (cmd == CMD_THROTTLE) && (sample > zero_r) &&
                     (sample < full_r) && (span_r != '0);

  bhcd_duty u_duty (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .excess (excess),
    .span   (span_r),
    .res    (dres)
  );

  always_comb begin
    state_nxt     = state_r;
    zero_nxt      = zero_r;
    full_nxt      = full_r;
    span_nxt      = span_r;
    drive_nxt     = drive_r;
    cmp_nxt       = cmp_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    stage_nxt     = stage_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_POINT: zero_nxt = cfg_data[SAMPLE_W-1:0];
        REG_FULL_POINT: full_nxt = cfg_data[SAMPLE_W-1:0];
        REG_SPAN:       span_nxt = cfg_data[SAMPLE_W-1:0];
        default:        ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EMIT;
          if (cmd == CMD_HALL) begin
            if (drive_r && hdec.valid) begin
              high_nxt  = stage_high(hdec.stage);
              low_nxt   = stage_low(hdec.stage);
              stage_nxt = hdec.stage;
            end else begin
              high_nxt  = PH_NONE;
              low_nxt   = PH_NONE;
              stage_nxt = STAGE_OFF;
            end
          end else if (sample > zero_r) begin
            // drive starts here: pattern comes from the hall bits of this item
            if (!drive_r) begin
              drive_nxt = 1'b1;
              if (hdec.valid) begin
                high_nxt  = stage_high(hdec.stage);
                low_nxt   = stage_low(hdec.stage);
                stage_nxt = hdec.stage;
              end else begin
                high_nxt  = PH_NONE;
                low_nxt   = PH_NONE;
                stage_nxt = STAGE_OFF;
              end
            end
            if (div_start) begin
              state_nxt = ST_DIV;
            end else begin
              cmp_nxt = '0;
            end
          end else begin
            drive_nxt = 1'b0;
            cmp_nxt   = CMP_W'(PWM_TOP);
            high_nxt  = PH_NONE;
            low_nxt   = PH_NONE;
            stage_nxt = STAGE_OFF;
          end
        end
      end
      ST_DIV: begin
        if (dres.done) begin
          cmp_nxt   = CMP_W'(TOP_W'(PWM_TOP) - dres.duty);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({drive_r, stage_r, cmp_r, low_r, high_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      zero_r      <= RST_ZERO_POINT;
      full_r      <= RST_FULL_POINT;
      span_r      <= RST_SPAN;
      drive_r     <= 1'b0;
      cmp_r       <= CMP_W'(PWM_TOP);
      high_r      <= PH_NONE;
      low_r       <= PH_NONE;
      stage_r     <= STAGE_OFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      zero_r      <= zero_nxt;
      full_r      <= full_nxt;
      span_r      <= span_nxt;
      drive_r     <= drive_nxt;
      cmp_r       <= cmp_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ dv/tb_bldc_hall_commutation_duty_unit.sv @@
`timescale 1ns / 1ps

module tb_bldc_hall_commutation_duty_unit;
  import bhcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned N_ROWS      = 28;
  localparam int unsigned TAIL_CYCLES = 40;

  // hall codes in forward rotation order, stage 0 first
  localparam logic [HALL_W-1:0] HALL_SEQ [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};

  typedef struct packed {
    logic [PHASE_W-1:0] high;
    logic [PHASE_W-1:0] low;
    logic [CMP_W-1:0]   cmp;
    logic [STAGE_W-1:0] stage;
    logic               drive;
  } drive_state_t;

  typedef enum logic { ROW_ITEM, ROW_REGS } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic                cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [HALL_W-1:0]   hall;
    logic [CFG_W-1:0]    zero, full, span;
    logic                fixed;
    drive_state_t        want;
  } row_t;

  localparam drive_state_t STOPPED = {PH_NONE, PH_NONE, CMP_W'(PWM_TOP), STAGE_OFF, 1'b0};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // directed rows may carry a hand-written expectation alongside the transfer
  logic                  row_fixed = 1'b0;
  drive_state_t          row_want = '0;

  bldc_hall_commutation_duty_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the block
  logic [CFG_W-1:0]   zero_pt, full_pt, span_pt;
  logic               m_drive;
  logic [CMP_W-1:0]   m_cmp;
  logic [PHASE_W-1:0] m_high, m_low;
  logic [STAGE_W-1:0] m_stage;

  drive_state_t awaited_states [$];
  int unsigned  issued, returned, checked_count, mismatches;
  int unsigned  n_throttle, n_hall, n_settings;
  bit           in_idle_on, out_stall_on;
  int unsigned  stall_left;
  row_t         script [N_ROWS];

  function automatic drive_state_t res(input logic [PHASE_W-1:0] hi,
                                       input logic [PHASE_W-1:0] lo,
                                       input logic [CMP_W-1:0] cmp,
                                       input logic [STAGE_W-1:0] st,
                                       input logic drv);
    return {hi, lo, cmp, st, drv};
  endfunction

  function automatic row_t item(input logic cmd, input logic [SAMPLE_W-1:0] s,
                                input logic [HALL_W-1:0] h);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.cmd = cmd;
    r.sample = s;
    r.hall = h;
    return r;
  endfunction

  function automatic row_t checked(input logic cmd, input logic [SAMPLE_W-1:0] s,
                                   input logic [HALL_W-1:0] h, input drive_state_t want);
    row_t r;
    r = item(cmd, s, h);
    r.fixed = 1'b1;
    r.want = want;
    return r;
  endfunction

  function automatic row_t regs(input logic [CFG_W-1:0] z, input logic [CFG_W-1:0] f,
                                input logic [CFG_W-1:0] s);
    row_t r;
    r = '0;
    r.kind = ROW_REGS;
    r.zero = z;
    r.full = f;
    r.span = s;
    return r;
  endfunction

  function automatic void apply_hall_code(input logic [HALL_W-1:0] hall);
    logic [STAGE_W-1:0] st;
    logic [PHASE_W-1:0] hi, lo;
    case (hall)
      3'd5: begin
        st = 3'd0; hi = PH_U; lo = PH_V;
      end
      3'd1: begin
        st = 3'd1; hi = PH_U; lo = PH_W;
      end
      3'd3: begin
        st = 3'd2; hi = PH_V; lo = PH_W;
      end
      3'd2: begin
        st = 3'd3; hi = PH_V; lo = PH_U;
      end
      3'd6: begin
        st = 3'd4; hi = PH_W; lo = PH_U;
      end
      3'd4: begin
        st = 3'd5; hi = PH_W; lo = PH_V;
      end
      default: begin
        st = STAGE_OFF; hi = PH_NONE; lo = PH_NONE;
      end
    endcase
    if (!m_drive) begin
      st = STAGE_OFF; hi = PH_NONE; lo = PH_NONE;
    end
    m_stage = st;
    m_high = hi;
    m_low = lo;
  endfunction

  function automatic drive_state_t advance_drive(input logic cmd,
                                                 input logic [SAMPLE_W-1:0] s,
                                                 input logic [HALL_W-1:0] hall);
    int unsigned duty;
    if (cmd == CMD_THROTTLE) begin
      if (s > zero_pt) begin
        if (s >= full_pt || span_pt == '0) begin
          duty = PWM_TOP;
        end else begin
          duty = (int'(s - zero_pt) * PWM_TOP) / span_pt;
          if (duty > PWM_TOP) duty = PWM_TOP;
        end
        if (!m_drive) begin
          m_drive = 1'b1;
          apply_hall_code(hall);
        end
        m_cmp = CMP_W'(PWM_TOP - duty);
      end else begin
        m_drive = 1'b0;
        m_cmp = CMP_W'(PWM_TOP);
        m_stage = STAGE_OFF;
        m_high = PH_NONE;
        m_low = PH_NONE;
      end
    end else begin
      apply_hall_code(hall);
    end
    return {m_high, m_low, m_cmp, m_stage, m_drive};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 92) return $urandom_range(2, 4);
    if (r < 98) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout: %0d results still awaited", awaited_states.size());
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 99) < 30) begin
      stall_left = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // transfers on all three channels, predictor kept in step
  always @(posedge clk) begin
    drive_state_t got, want;
    if (!rst_n) begin
      zero_pt = RST_ZERO_POINT;
      full_pt = RST_FULL_POINT;
      span_pt = RST_SPAN;
      m_drive = 1'b0;
      m_cmp = CMP_W'(PWM_TOP);
      m_high = PH_NONE;
      m_low = PH_NONE;
      m_stage = STAGE_OFF;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ZERO_POINT: zero_pt = cfg_data;
          REG_FULL_POINT: full_pt = cfg_data;
          REG_SPAN:       span_pt = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.high  = out_tdata[2:0];
        got.low   = out_tdata[5:3];
        got.cmp   = out_tdata[15:6];
        got.stage = out_tdata[18:16];
        got.drive = out_tdata[19];
        returned++;
        if (awaited_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: high %b low %b cmp %0d stage %0d drive %b",
                     got.high, got.low, got.cmp, got.stage, got.drive);
        end else begin
          want = awaited_states.pop_front();
          checked_count++;
          if (got.high !== want.high || got.low !== want.low || got.cmp !== want.cmp ||
              got.stage !== want.stage || got.drive !== want.drive) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected high %b low %b cmp %0d stage %0d drive %b,",
                        " got high %b low %b cmp %0d stage %0d drive %b"},
                       checked_count, want.high, want.low, want.cmp, want.stage, want.drive,
                       got.high, got.low, got.cmp, got.stage, got.drive);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = advance_drive(in_tuser, in_tdata[9:0], in_tdata[12:10]);
        awaited_states.push_back(row_fixed ? row_want : want);
        if (in_tuser == CMD_THROTTLE) n_throttle++;
        else n_hall++;
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] s,
                           input logic [HALL_W-1:0] hall, input logic fixed,
                           input drive_state_t want);
    int unsigned gap;
    gap = (in_idle_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {3'b000, hall, s};
    row_fixed <= fixed;
    row_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued++;
  endtask

  // hold the sender off until every awaited result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (returned != issued) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] z, input logic [CFG_W-1:0] f,
                          input logic [CFG_W-1:0] s);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_W-1:0]     vals [3];
    idx  = '{REG_ZERO_POINT, REG_FULL_POINT, REG_SPAN};
    vals = '{z, f, s};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int unsigned         pos, r;
    bit                  fwd;
    logic                cmd;
    logic [SAMPLE_W-1:0] s;
    logic [HALL_W-1:0]   hall;
    logic [CFG_W-1:0]    z, f, sp;

    script = '{
      checked(CMD_HALL,     10'd0,    3'd5, STOPPED),  // hall while stopped
      checked(CMD_THROTTLE, 10'd0,    3'd5, STOPPED),
      checked(CMD_THROTTLE, 10'd100,  3'd5, STOPPED),  // exactly at zero point
      checked(CMD_THROTTLE, 10'd1023, 3'd5, res(PH_U, PH_V, 10'd0, 3'd0, 1'b1)),
      checked(CMD_HALL,     10'd1023, 3'd1, res(PH_U, PH_W, 10'd0, 3'd1, 1'b1)),
      checked(CMD_HALL,     10'd0,    3'd3, res(PH_V, PH_W, 10'd0, 3'd2, 1'b1)),
      checked(CMD_HALL,     10'd0,    3'd2, res(PH_V, PH_U, 10'd0, 3'd3, 1'b1)),
      checked(CMD_HALL,     10'd0,    3'd6, res(PH_W, PH_U, 10'd0, 3'd4, 1'b1)),
      checked(CMD_HALL,     10'd0,    3'd4, res(PH_W, PH_V, 10'd0, 3'd5, 1'b1)),
      // bad hall codes: switches off, drive flag kept
      checked(CMD_HALL,     10'd0,    3'd0, res(PH_NONE, PH_NONE, 10'd0, STAGE_OFF, 1'b1)),
      checked(CMD_HALL,     10'd0,    3'd7, res(PH_NONE, PH_NONE, 10'd0, STAGE_OFF, 1'b1)),
      item(CMD_THROTTLE, 10'd500, 3'd6),
      item(CMD_THROTTLE, 10'd900, 3'd6),
      item(CMD_THROTTLE, 10'd101, 3'd6),
      item(CMD_THROTTLE, 10'd899, 3'd6),
      checked(CMD_THROTTLE, 10'd100, 3'd5, STOPPED),
      item(CMD_THROTTLE, 10'd101, 3'd0),                // start on a bad hall code
      item(CMD_HALL,     10'd0,   3'd5),
      checked(CMD_THROTTLE, 10'd0, 3'd7, STOPPED),
      regs(10'd0, 10'd1023, 10'd0),
      // zero span means full duty
      checked(CMD_THROTTLE, 10'd1, 3'd3, res(PH_V, PH_W, 10'd0, 3'd2, 1'b1)),
      regs(10'd600, 10'd300, 10'd1),
      item(CMD_THROTTLE, 10'd601, 3'd3),                // full point below zero point
      item(CMD_THROTTLE, 10'd600, 3'd3),
      regs(10'd0, 10'd1023, 10'd1),
      item(CMD_THROTTLE, 10'd2, 3'd4),                  // quotient clamps to top
      regs(10'd0, 10'd1023, 10'd1023),
      item(CMD_THROTTLE, 10'd1022, 3'd1)
    };

    in_idle_on = 1'b1;
    out_stall_on = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].kind == ROW_REGS) begin
        drain();
        set_regs(script[k].zero, script[k].full, script[k].span);
      end else begin
        send_item(script[k].cmd, script[k].sample, script[k].hall, script[k].fixed,
                  script[k].want);
      end
    end

    pos = 0;
    fwd = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          z = RST_ZERO_POINT; f = RST_FULL_POINT; sp = RST_SPAN;
        end
        1: begin
          z = '0; f = '1; sp = '1;
        end
        3: begin
          z = '0; f = '1; sp = '0;
        end
        4: begin
          z = $urandom_range(200, 700);
          f = $urandom_range(0, z);
          sp = $urandom_range(1, 1023);
        end
        5: begin
          z = $urandom_range(0, 1023);
          f = $urandom_range(0, 1023);
          sp = $urandom_range(0, 1023);
        end
        6: begin
          z = 10'd1022; f = '1; sp = 10'd1;
        end
        default: begin
          z = $urandom_range(0, 400);
          f = $urandom_range(z + 1, 1023);
          sp = f - z;
        end
      endcase
      set_regs(z, f, sp);
      in_idle_on = (ph % 4 == 0) || (ph % 4 == 2);
      out_stall_on = (ph % 4 < 2);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 1023);
        hall = HALL_SEQ[pos];
        if (r < 30) begin
          cmd = CMD_THROTTLE;
          case ($urandom_range(0, 9))
            0: s = '0;
            1: s = '1;
            2: s = zero_pt;
            3: s = zero_pt + 1'b1;
            4: s = full_pt;
            5: s = full_pt - 1'b1;
            6, 7: s = $urandom_range(zero_pt, 1023);
            default: ;
          endcase
          if ($urandom_range(0, 4) == 0) hall = $urandom_range(0, 7);
        end else begin
          cmd = CMD_HALL;
          if ($urandom_range(0, 49) == 0) fwd = ~fwd;
          if (r < 85) begin
            pos = fwd ? (pos + 1) % 6 : (pos + 5) % 6;
            hall = HALL_SEQ[pos];
          end else if (r < 93) begin
            hall = $urandom_range(0, 1) ? 3'd7 : 3'd0;
          end else begin
            hall = $urandom_range(0, 7);
          end
        end
        send_item(cmd, s, hall, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_states.size() != 0)
      $display("%0d expected results never arrived", awaited_states.size());
    $display("summary: %0d throttle and %0d hall transfers, %0d results checked",
             n_throttle, n_hall, checked_count);
    $display("summary: %0d threshold settings applied, %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0 && awaited_states.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
